>>> sv/mhpq_pkg.sv
package mhpq_pkg;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 7;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // latch the request word
      logic push_init;  // new entry goes to the bottom slot
      logic set_full;
      logic set_empty;
      logic rd_top;     // read slot 0
      logic del_init;   // read top and last, drop the count
      logic up_read;    // read the parent
      logic up_move;    // parent moves down into the hole
      logic dn_read;    // read both children
      logic dn_move;    // larger child moves up into the hole
      logic place;      // moving entry lands in the hole
      logic peek_cap;   // top read data to the result
      logic del_cap;    // removed top to the result, last entry starts moving
      logic emit;       // result to the output register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            up_swap;
      logic            up_at_root;
      logic            dn_leaf;
      logic            dn_swap;
      logic            rsp_free;
   } stat_type;

endpackage

>>> sv/mhpq_req_if.sv
interface mhpq_req_if #(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic [mhpq_pkg::OP_W-1:0]    operation;
   logic [KEY_BITS-1:0]          key;
   logic [TAG_BITS-1:0]          value;

   modport source (output valid, operation, key, value, input ready);
   modport sink   (input valid, operation, key, value, output ready);
endinterface

>>> sv/mhpq_rsp_if.sv
interface mhpq_rsp_if #(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 32
);
   logic                            valid;
   logic                            ready;
   logic [mhpq_pkg::STATUS_W-1:0]   status;
   logic [KEY_BITS-1:0]             out_key;
   logic [TAG_BITS-1:0]             out_value;
   logic [mhpq_pkg::COUNT_W-1:0]    count;
   logic                            is_empty;
   logic                            is_full;

   modport source (output valid, status, out_key, out_value, count, is_empty, is_full,
                   input ready);
   modport sink   (input valid, status, out_key, out_value, count, is_empty, is_full,
                   output ready);
endinterface

>>> sv/mhpq_csr_if.sv
interface mhpq_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mhpq_pkg::CAP_W-1:0]   capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

>>> sv/mhpq_ram.sv
module mhpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
   output logic [WIDTH-1:0]          rd_data_a,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
   output logic [WIDTH-1:0]          rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> sv/mhpq_ctrl.sv
module mhpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mhpq_pkg::stat_type  stat,
   output mhpq_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_UP_RD    = 4'd2;
   localparam logic [3:0] S_UP_CMP   = 4'd3;
   localparam logic [3:0] S_PLACE    = 4'd4;
   localparam logic [3:0] S_PEEK     = 4'd5;
   localparam logic [3:0] S_DEL      = 4'd6;
   localparam logic [3:0] S_DN_RD    = 4'd7;
   localparam logic [3:0] S_DN_CMP   = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               mhpq_pkg::OP_PUSH: begin
                  if (stat.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.push_init = 1'b1;
                     state_in      = stat.empty ? S_PLACE : S_UP_RD;
                  end
               end
               mhpq_pkg::OP_PEEK: begin
                  if (stat.empty) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_FINISH;
                  end else begin
                     cmd.rd_top = 1'b1;
                     state_in   = S_PEEK;
                  end
               end
               mhpq_pkg::OP_DELETE: begin
                  if (stat.empty) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_FINISH;
                  end else begin
                     cmd.del_init = 1'b1;
                     state_in     = S_DEL;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_UP_RD: begin
            cmd.up_read = 1'b1;
            state_in    = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (stat.up_swap) begin
               cmd.up_move = 1'b1;
               state_in    = stat.up_at_root ? S_PLACE : S_UP_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_FINISH;
         end
         S_PEEK: begin
            cmd.peek_cap = 1'b1;
            state_in     = S_FINISH;
         end
         S_DEL: begin
            cmd.del_cap = 1'b1;
            state_in    = stat.empty ? S_FINISH : S_DN_RD;
         end
         S_DN_RD: begin
            if (stat.dn_leaf) begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end else begin
               cmd.dn_read = 1'b1;
               state_in    = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (stat.dn_swap) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/mhpq_dpath.sv
module mhpq_dpath #(
   parameter int MAX_ENTRIES = 64,
   parameter int KEY_BITS    = 32,
   parameter int TAG_BITS    = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mhpq_pkg::cmd_type                 cmd,
   output mhpq_pkg::stat_type                stat,
   input  logic [mhpq_pkg::OP_W-1:0]         req_operation,
   input  logic [KEY_BITS-1:0]               req_key,
   input  logic [TAG_BITS-1:0]               req_value,
   input  logic                              csr_valid,
   input  logic [mhpq_pkg::CAP_W-1:0]        csr_capacity,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mhpq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [KEY_BITS-1:0]               rsp_out_key,
   output logic [TAG_BITS-1:0]               rsp_out_value,
   output logic [mhpq_pkg::COUNT_W-1:0]      rsp_count,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full
);

   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int CHILD_W = IDX_W + 2;
   localparam int CMP_W   = (CNT_W > mhpq_pkg::CAP_W) ? CNT_W : mhpq_pkg::CAP_W;
   localparam int ENT_W   = KEY_BITS + TAG_BITS;

   // request and working registers
   logic [mhpq_pkg::OP_W-1:0]      op_ff, op_in;
   logic [KEY_BITS-1:0]            cur_key_ff, cur_key_in;
   logic [TAG_BITS-1:0]            cur_tag_ff, cur_tag_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [mhpq_pkg::CAP_W-1:0]     cap_ff, cap_in;
   logic [mhpq_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [KEY_BITS-1:0]            res_key_ff, res_key_in;
   logic [TAG_BITS-1:0]            res_tag_ff, res_tag_in;

   // output register
   logic                           out_valid_ff, out_valid_in;
   logic [mhpq_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [KEY_BITS-1:0]            out_key_ff, out_key_in;
   logic [TAG_BITS-1:0]            out_tag_ff, out_tag_in;
   logic [mhpq_pkg::COUNT_W-1:0]   out_count_ff, out_count_in;
   logic                           out_empty_ff, out_empty_in;
   logic                           out_full_ff, out_full_in;

   logic [ENT_W-1:0]     rd_a_data, rd_b_data, wr_data;
   logic [KEY_BITS-1:0]  rd_a_key, rd_b_key, child_key;
   logic [TAG_BITS-1:0]  rd_a_tag, rd_b_tag, child_tag;
   logic [IDX_W-1:0]     rd_a_addr, rd_b_addr, parent_idx, last_idx, child_idx;
   logic [CHILD_W-1:0]   left_idx, right_idx, count_wide;
   logic [CMP_W-1:0]     count_ext;
   logic                 has_left, has_right, pick_right;
   logic                 full_now, empty_now, ram_we;

   assign rd_a_key = rd_a_data[ENT_W-1:TAG_BITS];
   assign rd_a_tag = rd_a_data[TAG_BITS-1:0];
   assign rd_b_key = rd_b_data[ENT_W-1:TAG_BITS];
   assign rd_b_tag = rd_b_data[TAG_BITS-1:0];

   // heap index arithmetic
   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign left_idx   = {1'b0, idx_ff, 1'b1};
   assign right_idx  = {1'b0, idx_ff, 1'b0} + CHILD_W'(2);
   assign count_wide = CHILD_W'(count_ff);
   assign has_left   = left_idx < count_wide;
   assign has_right  = right_idx < count_wide;

   // right child only when strictly larger
   assign pick_right = has_right && (rd_a_key < rd_b_key);
   assign child_key  = pick_right ? rd_b_key : rd_a_key;
   assign child_tag  = pick_right ? rd_b_tag : rd_a_tag;
   assign child_idx  = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

   assign count_ext = CMP_W'(count_ff);
   assign empty_now = (count_ff == '0);
   assign full_now  = (count_ext >= CMP_W'(cap_ff)) || (count_ff == CNT_W'(MAX_ENTRIES));

   assign stat.op         = op_ff;
   assign stat.full       = full_now;
   assign stat.empty      = empty_now;
   assign stat.up_swap    = rd_a_key < cur_key_ff;
   assign stat.up_at_root = (parent_idx == '0);
   assign stat.dn_leaf    = !has_left;
   assign stat.dn_swap    = cur_key_ff < child_key;
   assign stat.rsp_free   = !out_valid_ff || rsp_ready;

   // memory ports
   always_comb begin
      rd_a_addr = '0;
      if (cmd.up_read) begin
         rd_a_addr = parent_idx;
      end else if (cmd.dn_read) begin
         rd_a_addr = left_idx[IDX_W-1:0];
      end
   end

   assign rd_b_addr = cmd.dn_read ? right_idx[IDX_W-1:0] : last_idx;
   assign ram_we    = cmd.up_move || cmd.dn_move || cmd.place;

   always_comb begin
      wr_data = {cur_key_ff, cur_tag_ff};
      if (cmd.up_move) begin
         wr_data = rd_a_data;
      end else if (cmd.dn_move) begin
         wr_data = {child_key, child_tag};
      end
   end

   mhpq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (idx_ff),
      .wr_data   (wr_data),
      .rd_addr_a (rd_a_addr),
      .rd_data_a (rd_a_data),
      .rd_addr_b (rd_b_addr),
      .rd_data_b (rd_b_data)
   );

   // next values
   always_comb begin
      op_in         = op_ff;
      cur_key_in    = cur_key_ff;
      cur_tag_in    = cur_tag_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      cap_in        = csr_valid ? csr_capacity : cap_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;

      if (cmd.load_req) begin
         op_in         = req_operation;
         cur_key_in    = req_key;
         cur_tag_in    = req_value;
         res_status_in = mhpq_pkg::STATUS_OK;
         res_key_in    = '0;
         res_tag_in    = '0;
      end
      if (cmd.set_full) begin
         res_status_in = mhpq_pkg::STATUS_FULL;
      end
      if (cmd.set_empty) begin
         res_status_in = mhpq_pkg::STATUS_EMPTY;
      end
      if (cmd.push_init) begin
         idx_in   = IDX_W'(count_ff);
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.del_init) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.up_move) begin
         idx_in = parent_idx;
      end
      if (cmd.dn_move) begin
         idx_in = child_idx;
      end
      if (cmd.peek_cap || cmd.del_cap) begin
         res_key_in = rd_a_key;
         res_tag_in = rd_a_tag;
      end
      if (cmd.del_cap) begin
         cur_key_in = rd_b_key;
         cur_tag_in = rd_b_tag;
         idx_in     = '0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_key_in    = out_key_ff;
      out_tag_in    = out_tag_ff;
      out_count_in  = out_count_ff;
      out_empty_in  = out_empty_ff;
      out_full_in   = out_full_ff;
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_key_in    = res_key_ff;
         out_tag_in    = res_tag_ff;
         out_count_in  = count_ext[mhpq_pkg::COUNT_W-1:0];
         out_empty_in  = empty_now;
         out_full_in   = full_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= mhpq_pkg::CAP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cur_key_ff    <= cur_key_in;
      cur_tag_ff    <= cur_tag_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      out_status_ff <= out_status_in;
      out_key_ff    <= out_key_in;
      out_tag_ff    <= out_tag_in;
      out_count_ff  <= out_count_in;
      out_empty_ff  <= out_empty_in;
      out_full_ff   <= out_full_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_out_key   = out_key_ff;
   assign rsp_out_value = out_tag_ff;
   assign rsp_count     = out_count_ff;
   assign rsp_is_empty  = out_empty_ff;
   assign rsp_is_full   = out_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above heap depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CNT_W'(idx_ff) < count_ff))
      else $error("heap write outside live entries");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_ready))
      else $error("result overwrites a word not yet taken");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.push_init |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the count");

endmodule

>>> sv/max_heap_priority_queue.sv
// channel   dir  handshake      word
// req_chan  in   valid/ready    operation, key, value
// rsp_chan  out  valid/ready    status, out_key, out_value, count, is_empty, is_full
// csr_chan  in   valid/ready    capacity (always ready, written at once)
//
// one request word at a time; a push or delete walks the heap with one read step and one
// compare and write step per heap level walked, up to log2(MAX_ENTRIES) levels
// peek reads the top before the result; full, empty and unknown operations go straight to it
// the sift loop over the single two-read, one-write entry memory sets the rate
// reset (synchronous) clears the count and sets capacity to 64; heap memory is not cleared
// a new request word is taken while the previous result still waits on rsp_chan
module max_heap_priority_queue #(
   parameter int MAX_ENTRIES = 64,
   parameter int KEY_BITS    = 32,
   parameter int TAG_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   mhpq_req_if.sink    req_chan,
   mhpq_rsp_if.source  rsp_chan,
   mhpq_csr_if.sink    csr_chan
);

   mhpq_pkg::cmd_type   cmd;
   mhpq_pkg::stat_type  stat;

   // capacity register never stalls
   assign csr_chan.ready = 1'b1;

   // sequencer: dispatch, sift up, sift down, result hand-off
   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry memory, moving entry, index and count, result and output registers
   mhpq_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BITS    (KEY_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_chan.operation),
      .req_key       (req_chan.key),
      .req_value     (req_chan.value),
      .csr_valid     (csr_chan.valid),
      .csr_capacity  (csr_chan.capacity),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_status    (rsp_chan.status),
      .rsp_out_key   (rsp_chan.out_key),
      .rsp_out_value (rsp_chan.out_value),
      .rsp_count     (rsp_chan.count),
      .rsp_is_empty  (rsp_chan.is_empty),
      .rsp_is_full   (rsp_chan.is_full)
   );

endmodule

>>> bench/max_heap_priority_queue_tb.sv
module max_heap_priority_queue_tb;

   localparam int MAX_ENTRIES = 64;
   localparam int KEY_BITS    = 32;
   localparam int TAG_BITS    = 32;

   // unused operation code, block reports count and flags only
   localparam logic [mhpq_pkg::OP_W-1:0] OP_NONE = 2'd3;

   // cycles to let the block settle once all words have come back
   localparam int SETTLE_CYCLES = 20;
   localparam int TIMEOUT_UNITS = 8_000_000;

   // per phase: sender idle percent, receiver stall percent, capacity, word count
   localparam int PHASE_COUNT = 9;
   localparam int PHASE_SEND[PHASE_COUNT] = '{0, 62, 0, 25, 0, 62, 0, 25, 0};
   localparam int PHASE_RECV[PHASE_COUNT] = '{0, 0, 62, 25, 0, 0, 62, 25, 0};
   localparam int PHASE_CAP[PHASE_COUNT]  = '{64, 127, 2, 17, 0, 64, 1, 40, 64};
   localparam int PHASE_LEN[PHASE_COUNT]  = '{165, 165, 165, 165, 30, 165, 165, 165, 165};

   typedef enum {WORK_OP, WORK_CAP, WORK_MODE, WORK_DRAIN} work_kind_type;

   typedef struct {
      work_kind_type                  kind;
      logic [mhpq_pkg::OP_W-1:0]      op;
      logic [KEY_BITS-1:0]            key;
      logic [TAG_BITS-1:0]            tag;
      logic [mhpq_pkg::CAP_W-1:0]     cap;
      int                             send_pct;
      int                             recv_pct;
   } work_item_type;

   typedef struct packed {
      logic [mhpq_pkg::STATUS_W-1:0]  status;
      logic [KEY_BITS-1:0]            key;
      logic [TAG_BITS-1:0]            tag;
      logic [mhpq_pkg::COUNT_W-1:0]   count;
      logic                           empty;
      logic                           full;
   } heap_result_type;

   logic clock;
   logic reset;

   mhpq_req_if #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) req_bus ();
   mhpq_rsp_if #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) rsp_bus ();
   mhpq_csr_if csr_bus ();

   max_heap_priority_queue #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BITS    (KEY_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // shadow heap, updated as each request word is accepted
   logic [KEY_BITS-1:0]          shadow_keys[MAX_ENTRIES];
   logic [TAG_BITS-1:0]          shadow_tags[MAX_ENTRIES];
   int unsigned                  shadow_count = 0;
   logic [mhpq_pkg::CAP_W-1:0]   shadow_cap   = mhpq_pkg::CAP_RESET;

   work_item_type   op_backlog[$];
   heap_result_type heap_results_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_left    = SETTLE_CYCLES;
   int error_count   = 0;
   int result_index  = 0;

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [KEY_BITS-1:0] k;
      logic [TAG_BITS-1:0] t;
      k = shadow_keys[a];
      t = shadow_tags[a];
      shadow_keys[a] = shadow_keys[b];
      shadow_tags[a] = shadow_tags[b];
      shadow_keys[b] = k;
      shadow_tags[b] = t;
   endfunction

   function automatic heap_result_type apply_heap_op(logic [mhpq_pkg::OP_W-1:0] op,
                                                     logic [KEY_BITS-1:0] key,
                                                     logic [TAG_BITS-1:0] tag);
      heap_result_type res;
      int unsigned     lim;
      int unsigned     i;
      int unsigned     p;
      int unsigned     c;
      int unsigned     last;
      lim = (shadow_cap > MAX_ENTRIES) ? MAX_ENTRIES : shadow_cap;
      res = '0;
      res.status = mhpq_pkg::STATUS_OK;
      case (op)
         mhpq_pkg::OP_PUSH: begin
            if (shadow_count >= lim) begin
               res.status = mhpq_pkg::STATUS_FULL;
            end else begin
               i = shadow_count;
               shadow_keys[i] = key;
               shadow_tags[i] = tag;
               shadow_count++;
               // sift up, equal keys stay put
               while (i > 0) begin
                  p = (i - 1) / 2;
                  if (!(shadow_keys[p] < shadow_keys[i])) break;
                  swap_slots(i, p);
                  i = p;
               end
            end
         end
         mhpq_pkg::OP_PEEK, mhpq_pkg::OP_DELETE: begin
            if (shadow_count == 0) begin
               res.status = mhpq_pkg::STATUS_EMPTY;
            end else if (op == mhpq_pkg::OP_PEEK) begin
               res.key = shadow_keys[0];
               res.tag = shadow_tags[0];
            end else begin
               last = shadow_count - 1;
               swap_slots(0, last);
               // sift down over the remaining entries, right child only if strictly larger
               i = 0;
               while (2 * i + 1 < last) begin
                  c = 2 * i + 1;
                  if (c + 1 < last && shadow_keys[c] < shadow_keys[c + 1]) c++;
                  if (!(shadow_keys[i] < shadow_keys[c])) break;
                  swap_slots(i, c);
                  i = c;
               end
               res.key = shadow_keys[last];
               res.tag = shadow_tags[last];
               shadow_count = last;
            end
         end
         default: ;
      endcase
      res.count = shadow_count[mhpq_pkg::COUNT_W-1:0];
      res.empty = (shadow_count == 0);
      res.full  = (shadow_count >= lim);
      return res;
   endfunction

   function automatic void queue_op(logic [mhpq_pkg::OP_W-1:0] op,
                                    logic [KEY_BITS-1:0] key,
                                    logic [TAG_BITS-1:0] tag);
      work_item_type w;
      w = '{kind: WORK_OP, op: op, key: key, tag: tag, cap: '0, send_pct: 0, recv_pct: 0};
      op_backlog.push_back(w);
   endfunction

   function automatic void queue_cap(logic [mhpq_pkg::CAP_W-1:0] cap);
      work_item_type w;
      w = '{kind: WORK_CAP, op: OP_NONE, key: '0, tag: '0, cap: cap, send_pct: 0,
            recv_pct: 0};
      op_backlog.push_back(w);
   endfunction

   function automatic void queue_mode(int send_pct, int recv_pct);
      work_item_type w;
      w = '{kind: WORK_MODE, op: OP_NONE, key: '0, tag: '0, cap: '0, send_pct: send_pct,
            recv_pct: recv_pct};
      op_backlog.push_back(w);
   endfunction

   function automatic void queue_drain();
      work_item_type w;
      w = '{kind: WORK_DRAIN, op: OP_NONE, key: '0, tag: '0, cap: '0, send_pct: 0,
            recv_pct: 0};
      op_backlog.push_back(w);
   endfunction

   // mix of wide random keys, a narrow range for ties, and the extremes
   function automatic logic [KEY_BITS-1:0] pick_key();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: begin
            case ($urandom_range(3))
               0: return '0;
               1: return '1;
               2: return 32'h8000_0000;
               default: return 32'h7fff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // first part of a phase fills the heap, the rest empties it
   function automatic void queue_random_phase(int len);
      int                          fill_len;
      int                          r;
      logic [mhpq_pkg::OP_W-1:0]   op;
      fill_len = len * 6 / 10;
      for (int n = 0; n < len; n++) begin
         if (n == len / 2) queue_drain();
         r = $urandom_range(99);
         if (n < fill_len)
            op = (r < 80) ? mhpq_pkg::OP_PUSH : (r < 88) ? mhpq_pkg::OP_DELETE :
                 (r < 96) ? mhpq_pkg::OP_PEEK : OP_NONE;
         else
            op = (r < 20) ? mhpq_pkg::OP_PUSH : (r < 80) ? mhpq_pkg::OP_DELETE :
                 (r < 95) ? mhpq_pkg::OP_PEEK : OP_NONE;
         queue_op(op, pick_key(), $urandom);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_NONE;
      req_bus.key       = '0;
      req_bus.value     = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.capacity  = mhpq_pkg::CAP_RESET;

      // directed: empty heap, extremes, ties, peek and delete to empty
      queue_mode(0, 0);
      queue_op(mhpq_pkg::OP_PEEK, '1, '1);
      queue_op(mhpq_pkg::OP_DELETE, '1, '1);
      queue_op(OP_NONE, 32'hdead_beef, 32'h0bad_f00d);
      queue_op(mhpq_pkg::OP_PUSH, '0, '0);
      queue_op(mhpq_pkg::OP_PUSH, '1, '1);
      queue_op(mhpq_pkg::OP_PUSH, 32'd5, 32'ha5a5_a5a5);
      queue_op(mhpq_pkg::OP_PUSH, 32'd5, 32'h5a5a_5a5a);
      queue_op(mhpq_pkg::OP_PUSH, '1, 32'h1234_5678);
      queue_op(mhpq_pkg::OP_PEEK, '0, '0);
      queue_op(OP_NONE, $urandom, $urandom);
      repeat (5) queue_op(mhpq_pkg::OP_DELETE, '0, '0);
      // tiny capacity, push until full
      queue_cap(7'd2);
      queue_op(mhpq_pkg::OP_PUSH, 32'd9, 32'h0000_0001);
      queue_op(mhpq_pkg::OP_PUSH, 32'd9, 32'h0000_0002);
      queue_op(mhpq_pkg::OP_PUSH, 32'd10, 32'h0000_0003);
      queue_op(OP_NONE, '0, '0);
      queue_op(mhpq_pkg::OP_PEEK, '0, '0);
      // capacity dropped below the count keeps the entries
      queue_cap(7'd1);
      queue_op(mhpq_pkg::OP_PUSH, 32'd11, 32'h0000_0004);
      queue_op(mhpq_pkg::OP_DELETE, '0, '0);
      queue_op(mhpq_pkg::OP_DELETE, '0, '0);
      // zero capacity refuses every push
      queue_cap(7'd0);
      queue_op(mhpq_pkg::OP_PUSH, 32'd12, 32'h0000_0005);
      queue_op(mhpq_pkg::OP_PEEK, '0, '0);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         queue_cap(PHASE_CAP[ph][mhpq_pkg::CAP_W-1:0]);
         queue_mode(PHASE_SEND[ph], PHASE_RECV[ph]);
         queue_random_phase(PHASE_LEN[ph]);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || req_bus.valid || heap_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && heap_results_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // request and capacity driver
   always @(posedge clock) begin : drive_proc
      logic req_take;
      logic csr_take;
      logic req_next;
      logic csr_next;
      req_take = req_bus.valid && req_bus.ready;
      csr_take = csr_bus.valid && csr_bus.ready;
      req_next = req_bus.valid && !req_take;
      csr_next = csr_bus.valid && !csr_take;
      if (req_take)
         heap_results_due.push_back(apply_heap_op(req_bus.operation, req_bus.key,
                                                  req_bus.value));
      if (csr_take) shadow_cap = csr_bus.capacity;

      if (reset) begin
         req_next = 1'b0;
         csr_next = 1'b0;
      end else if (!req_next && !csr_next && op_backlog.size() != 0) begin
         case (op_backlog[0].kind)
            WORK_MODE: begin
               send_idle_pct <= op_backlog[0].send_pct;
               recv_idle_pct <= op_backlog[0].recv_pct;
               void'(op_backlog.pop_front());
            end
            WORK_OP: begin
               if ($urandom_range(99) >= send_idle_pct) begin
                  req_bus.operation <= op_backlog[0].op;
                  req_bus.key       <= op_backlog[0].key;
                  req_bus.value     <= op_backlog[0].tag;
                  req_next = 1'b1;
                  void'(op_backlog.pop_front());
               end
            end
            default: begin
               // hold off until every word is back and the block has gone quiet
               if (heap_results_due.size() != 0) begin
                  quiet_left = SETTLE_CYCLES;
               end else if (quiet_left != 0) begin
                  quiet_left--;
               end else begin
                  if (op_backlog[0].kind == WORK_CAP) begin
                     csr_bus.capacity <= op_backlog[0].cap;
                     csr_next = 1'b1;
                  end
                  void'(op_backlog.pop_front());
                  quiet_left = SETTLE_CYCLES;
               end
            end
         endcase
      end
      req_bus.valid <= req_next;
      csr_bus.valid <= csr_next;
   end

   // result checker and ready stalls
   always @(posedge clock) begin : check_proc
      heap_result_type got;
      heap_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{status: rsp_bus.status, key: rsp_bus.out_key, tag: rsp_bus.out_value,
                 count: rsp_bus.count, empty: rsp_bus.is_empty, full: rsp_bus.is_full};
         if (heap_results_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("result %0d arrived with nothing outstanding: status %0d key %h",
                        result_index, got.status, got.key);
         end else begin
            want = heap_results_due.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("result %0d mismatch", result_index);
                  $display("  expected status %0d key %h value %h count %0d empty %b full %b",
                           want.status, want.key, want.tag, want.count, want.empty,
                           want.full);
                  $display("  actual   status %0d key %h value %h count %0d empty %b full %b",
                           got.status, got.key, got.tag, got.count, got.empty, got.full);
               end
            end
         end
         result_index++;
      end
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

endmodule
